/* hdl/sbfl_pkg.sv */
// Shared types, widths and codes for the sharded buffer free list.
// Used by the channel interfaces, the remainder unit and the top level.
package sbfl_pkg;

    localparam int MAX_BUFFERS = 256;
    localparam int MAX_SHARDS  = 8;

    localparam int BUF_W      = 8;   // buffer index
    localparam int LINK_W     = 9;   // buffer index plus the empty marker
    localparam int SHARD_W    = 3;   // shard number
    localparam int SHARD_CNT_W = 4;  // shard count, 1 to 8
    localparam int CNT_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [LINK_W-1:0] EMPTY_MARK = LINK_W'(MAX_BUFFERS);
    localparam logic [LINK_W-1:0] MAX_N      = LINK_W'(MAX_BUFFERS);
    localparam logic [SHARD_CNT_W-1:0] MAX_K = SHARD_CNT_W'(MAX_SHARDS);

    localparam logic OP_BORROW = 1'b0;
    localparam logic OP_RETURN = 1'b1;

    localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RETURNED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BUFFERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARDS  = 2'd1;

    // Request to the shared remainder unit.
    typedef struct packed {
        logic                   start;
        logic [BUF_W-1:0]       dividend;
        logic [SHARD_CNT_W-1:0] divisor;
    } t_mod_req;

    // Answer of the shared remainder unit.
    typedef struct packed {
        logic               done;
        logic [SHARD_W-1:0] rem;
    } t_mod_rsp;

endpackage

/* hdl/sbfl_ifs.sv */
// Valid/ready channel interfaces of the sharded buffer free list.
// Depends on sbfl_pkg for the payload widths.
interface sbfl_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [sbfl_pkg::SHARD_W-1:0] first_shard;
    logic [sbfl_pkg::BUF_W-1:0]   buffer_index;

    modport source (output valid, op, first_shard, buffer_index, input ready);
    modport sink   (input valid, op, first_shard, buffer_index, output ready);
endinterface

interface sbfl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sbfl_pkg::STATUS_W-1:0] status;
    logic [sbfl_pkg::BUF_W-1:0]    granted_index;
    logic [sbfl_pkg::SHARD_W-1:0]  granted_shard;
    logic [sbfl_pkg::LINK_W-1:0]   available_total;
    logic [sbfl_pkg::CNT_W-1:0]    borrow_total;
    logic [sbfl_pkg::CNT_W-1:0]    return_total;

    modport source (output valid, status, granted_index, granted_shard, available_total,
                    borrow_total, return_total, input ready);
    modport sink   (input valid, status, granted_index, granted_shard, available_total,
                    borrow_total, return_total, output ready);
endinterface

interface sbfl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sbfl_pkg::CFG_IDX_W-1:0]  index;
    logic [sbfl_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/sbfl_mod_unit.sv */
// Shared remainder unit: 8-bit dividend modulo a shard count of 1 to 8.
// Restoring remainder, two dividend bits per cycle; depends on sbfl_pkg.
module sbfl_mod_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbfl_pkg::t_mod_req i_req,
    output sbfl_pkg::t_mod_rsp o_rsp
);

    // One restoring step; the remainder stays below the divisor, so 3 bits.
    function automatic logic [sbfl_pkg::SHARD_W-1:0] mod_step(
        input logic [sbfl_pkg::SHARD_W-1:0]     rem,
        input logic                             bit_in,
        input logic [sbfl_pkg::SHARD_CNT_W-1:0] div
    );
        logic [sbfl_pkg::SHARD_CNT_W-1:0] t;
        t = {rem, bit_in};
        if (t >= div) begin
            t = t - div;
        end
        return t[sbfl_pkg::SHARD_W-1:0];
    endfunction

    logic                             r_busy;
    logic [1:0]                       r_cnt;
    logic [sbfl_pkg::BUF_W-1:0]       r_val;
    logic [sbfl_pkg::SHARD_CNT_W-1:0] r_div;
    logic [sbfl_pkg::SHARD_W-1:0]     r_rem;
    logic [sbfl_pkg::SHARD_W-1:0]     rem_a;
    logic [sbfl_pkg::SHARD_W-1:0]     rem_b;

    assign rem_a = mod_step(r_rem, r_val[sbfl_pkg::BUF_W-1], r_div);
    assign rem_b = mod_step(rem_a, r_val[sbfl_pkg::BUF_W-2], r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 2'd1;
            if (r_cnt == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_val <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[sbfl_pkg::BUF_W-3:0], 2'b00};
            r_rem <= rem_b;
        end
    end

    assign o_rsp.done = r_busy && (r_cnt == 2'd3);
    assign o_rsp.rem  = rem_b;

endmodule

/* hdl/sharded_buffer_free_list_core.sv */
// Top level of the sharded buffer free list: sequencer, shard heads and link memory.
// Depends on sbfl_pkg, the channel interfaces in sbfl_ifs.sv and sbfl_mod_unit.
//
//   Channel  | Direction | Payload
//   ---------+-----------+--------------------------------------------------------
//   i_req    | in        | op, first_shard, buffer_index
//   o_rsp    | out       | status, granted_index, granted_shard, available_total,
//            |           | borrow_total, return_total
//   i_cfg    | in        | index (0 buffers_in_use, 1 shards_in_use), data
//
// A request is accepted in idle; an out-of-range return then goes straight to hand-over.
// Other requests pass the shared remainder unit (shard = value mod shard count), then a
// borrow probes one shard after another (1 to 8) and pops, a return pushes, and both
// end in hand-over. Reset and every write to a known register rebuild the lists:
// a clear state, then a sweep that writes one link entry a cycle for each managed
// buffer; no request is accepted meanwhile or while a configuration write is offered.
// A finished result sits in the output register; the next request is accepted while
// it waits, and a second result waits in the sequencer until the first is taken.
module sharded_buffer_free_list_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sbfl_req_if.sink         i_req,
    sbfl_rsp_if.source       o_rsp,
    sbfl_cfg_if.sink         i_cfg
);

    localparam logic [2:0] S_SWEEP_INIT = 3'd0;
    localparam logic [2:0] S_SWEEP      = 3'd1;
    localparam logic [2:0] S_IDLE       = 3'd2;
    localparam logic [2:0] S_MOD        = 3'd3;
    localparam logic [2:0] S_SEARCH     = 3'd4;
    localparam logic [2:0] S_POP        = 3'd5;
    localparam logic [2:0] S_PUSH       = 3'd6;
    localparam logic [2:0] S_DONE       = 3'd7;

    localparam int LW = sbfl_pkg::LINK_W;
    localparam int BW = sbfl_pkg::BUF_W;
    localparam int SW = sbfl_pkg::SHARD_W;
    localparam int KW = sbfl_pkg::SHARD_CNT_W;
    localparam int CW = sbfl_pkg::CNT_W;

    // Configuration registers, raw as written.
    logic [LW-1:0] r_buffers;
    logic [KW-1:0] r_shards;

    // Sequencer and working registers.
    logic [2:0]    r_state, n_state;
    logic [LW-1:0] r_i, n_i;           // sweep position, can reach the buffer count
    logic [SW-1:0] r_s, n_s;           // current shard
    logic [SW-1:0] r_tries, n_tries;   // shards probed so far in a borrow
    logic          r_op, n_op;
    logic [BW-1:0] r_idx, n_idx;
    logic [sbfl_pkg::STATUS_W-1:0] r_status, n_status;
    logic [BW-1:0] r_gidx, n_gidx;
    logic [SW-1:0] r_gshard, n_gshard;
    logic [LW-1:0] r_avail, n_avail;
    logic [CW-1:0] r_borrow, n_borrow;
    logic [CW-1:0] r_return, n_return;

    // Shard heads in flip-flops, link memory as RAM with a registered read.
    logic [LW-1:0] r_head [sbfl_pkg::MAX_SHARDS];
    logic [LW-1:0] r_link [sbfl_pkg::MAX_BUFFERS];
    logic [LW-1:0] r_link_rd;
    logic [LW-1:0] head_rd;
    logic          head_we;
    logic          head_clear;
    logic [LW-1:0] head_wdata;
    logic          mem_we;
    logic [BW-1:0] mem_waddr;

    // Output register.
    logic          r_out_valid;
    logic [sbfl_pkg::STATUS_W-1:0] r_out_status;
    logic [BW-1:0] r_out_gidx;
    logic [SW-1:0] r_out_gshard;
    logic [LW-1:0] r_out_avail;
    logic [CW-1:0] r_out_borrow;
    logic [CW-1:0] r_out_return;
    logic          out_load;

    logic          in_acc;
    logic          cfg_acc;
    logic          cfg_rebuild;
    logic [LW-1:0] eff_n;
    logic [KW-1:0] eff_k;
    logic [SW-1:0] s_next;
    logic          last_shard;
    logic          last_try;

    sbfl_pkg::t_mod_req mod_req;
    sbfl_pkg::t_mod_rsp mod_rsp;

    sbfl_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    // Out-of-range register values are clamped to the supported range.
    always_comb begin
        if (r_buffers == '0) begin
            eff_n = LW'(1);
        end else if (r_buffers > sbfl_pkg::MAX_N) begin
            eff_n = sbfl_pkg::MAX_N;
        end else begin
            eff_n = r_buffers;
        end
        if (r_shards == '0) begin
            eff_k = KW'(1);
        end else if (r_shards > sbfl_pkg::MAX_K) begin
            eff_k = sbfl_pkg::MAX_K;
        end else begin
            eff_k = r_shards;
        end
    end

    assign in_acc     = i_req.valid && i_req.ready;
    assign cfg_acc    = i_cfg.valid && i_cfg.ready;
    // Only the two known registers trigger a rebuild; other indexes are dropped.
    assign cfg_rebuild = cfg_acc && ((i_cfg.index == sbfl_pkg::CFG_BUFFERS) ||
                                     (i_cfg.index == sbfl_pkg::CFG_SHARDS));
    // A pending configuration write keeps a new request from slipping in beside it.
    assign i_req.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = 1'b1;

    assign head_rd    = r_head[r_s];
    assign last_shard = (({1'b0, r_s} + KW'(1)) == eff_k);
    assign s_next     = last_shard ? '0 : r_s + SW'(1);
    assign last_try   = (({1'b0, r_tries} + KW'(1)) == eff_k);

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_s      = r_s;
        n_tries  = r_tries;
        n_op     = r_op;
        n_idx    = r_idx;
        n_status = r_status;
        n_gidx   = r_gidx;
        n_gshard = r_gshard;
        n_avail  = r_avail;
        n_borrow = r_borrow;
        n_return = r_return;
        head_we    = 1'b0;
        head_clear = 1'b0;
        head_wdata = r_link_rd;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        out_load   = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = i_req.buffer_index;
        mod_req.divisor  = eff_k;

        unique case (r_state)
            S_SWEEP_INIT: begin
                head_clear = 1'b1;
                n_i        = '0;
                n_s        = '0;
                n_avail    = eff_n;
                n_state    = S_SWEEP;
            end
            S_SWEEP: begin
                // Buffer i goes onto the head of shard i mod k, ascending.
                if (r_i == eff_n) begin
                    n_state = S_IDLE;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = r_i[BW-1:0];
                    head_we    = 1'b1;
                    head_wdata = {1'b0, r_i[BW-1:0]};
                    n_i        = r_i + LW'(1);
                    n_s        = s_next;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_op     = i_req.op;
                    n_idx    = i_req.buffer_index;
                    n_gidx   = '0;
                    n_gshard = '0;
                    n_tries  = '0;
                    if ((i_req.op == sbfl_pkg::OP_RETURN) &&
                        ({1'b0, i_req.buffer_index} >= eff_n)) begin
                        n_status = sbfl_pkg::ST_RANGE;
                        n_state  = S_DONE;
                    end else begin
                        mod_req.start = 1'b1;
                        if (i_req.op == sbfl_pkg::OP_BORROW) begin
                            mod_req.dividend = BW'(i_req.first_shard);
                        end
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (mod_rsp.done) begin
                    n_s     = mod_rsp.rem;
                    n_state = (r_op == sbfl_pkg::OP_RETURN) ? S_PUSH : S_SEARCH;
                end
            end
            S_SEARCH: begin
                // The link memory read of the head issues here and lands for S_POP.
                if (!head_rd[LW-1]) begin
                    n_state = S_POP;
                end else if (last_try) begin
                    n_status = sbfl_pkg::ST_EMPTY;
                    n_state  = S_DONE;
                end else begin
                    n_s     = s_next;
                    n_tries = r_tries + SW'(1);
                end
            end
            S_POP: begin
                head_we    = 1'b1;
                head_wdata = r_link_rd;
                n_gidx     = head_rd[BW-1:0];
                n_gshard   = r_s;
                n_borrow   = r_borrow + CW'(1);
                n_avail    = r_avail - LW'(1);
                n_status   = sbfl_pkg::ST_GRANTED;
                n_state    = S_DONE;
            end
            S_PUSH: begin
                mem_we     = 1'b1;
                mem_waddr  = r_idx;
                head_we    = 1'b1;
                head_wdata = {1'b0, r_idx};
                n_return   = r_return + CW'(1);
                n_avail    = r_avail + LW'(1);
                n_status   = sbfl_pkg::ST_RETURNED;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_SWEEP_INIT;
            end
        endcase

        // A write to a known register restarts the rebuild from scratch.
        if (cfg_rebuild) begin
            n_state = S_SWEEP_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP_INIT;
            r_buffers   <= sbfl_pkg::MAX_N;
            r_shards    <= KW'(1);
            r_borrow    <= '0;
            r_return    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_borrow <= n_borrow;
            r_return <= n_return;
            if (cfg_acc) begin
                if (i_cfg.index == sbfl_pkg::CFG_BUFFERS) begin
                    r_buffers <= i_cfg.data;
                end else if (i_cfg.index == sbfl_pkg::CFG_SHARDS) begin
                    r_shards <= i_cfg.data[KW-1:0];
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_s      <= n_s;
        r_tries  <= n_tries;
        r_op     <= n_op;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_gidx   <= n_gidx;
        r_gshard <= n_gshard;
        r_avail  <= n_avail;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_gidx   <= r_gidx;
            r_out_gshard <= r_gshard;
            r_out_avail  <= r_avail;
            r_out_borrow <= r_borrow;
            r_out_return <= r_return;
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_clear) begin
            for (int k = 0; k < sbfl_pkg::MAX_SHARDS; k++) begin
                r_head[k] <= sbfl_pkg::EMPTY_MARK;
            end
        end else if (head_we) begin
            r_head[r_s] <= head_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link[mem_waddr] <= head_rd;
        end
        r_link_rd <= r_link[head_rd[BW-1:0]];
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.granted_index   = r_out_gidx;
    assign o_rsp.granted_shard   = r_out_gshard;
    assign o_rsp.available_total = r_out_avail;
    assign o_rsp.borrow_total    = r_out_borrow;
    assign o_rsp.return_total    = r_out_return;

`ifndef SYNTHESIS
    // Every write to a known register sends the block into a rebuild.
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_rebuild |=> (r_state == S_SWEEP_INIT))
        else $error("configuration write did not start a rebuild");

    // An accepted request keeps the sequencer busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !cfg_acc) |=> (r_state != S_IDLE))
        else $error("sequencer idle right after accepting a request");

    // A popped head is a real buffer inside the managed range.
    a_pop_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (!head_rd[LW-1] && (head_rd < eff_n)))
        else $error("pop from an empty or out-of-range head");

    // The rebuild sweep ends exactly when every managed buffer is linked.
    a_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SWEEP) && (r_i == eff_n) && !cfg_acc) |=> (r_state == S_IDLE))
        else $error("rebuild sweep did not finish at the buffer count");
`endif

endmodule

/* tb/sharded_buffer_free_list_core_test.sv */
// Self-checking testbench for sharded_buffer_free_list_core: directed and random borrow and
// return requests, checked against a behavioral free-list model kept in a scoreboard class.
// Depends on sbfl_pkg, the channel interfaces in sbfl_ifs.sv and the block itself.
`timescale 1ns / 100ps

module sharded_buffer_free_list_core_test;

    // Cycles without any handshake on any channel before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off or a rebuild, plus one request.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASES = 12;
    localparam int ITEMS_PER_PHASE = 158;
    localparam int TAIL_CYCLES = 30;

    // One result of the block, as it appears on the response channel.
    typedef struct packed {
        logic [sbfl_pkg::STATUS_W-1:0] status;
        logic [sbfl_pkg::BUF_W-1:0]    granted_index;
        logic [sbfl_pkg::SHARD_W-1:0]  granted_shard;
        logic [sbfl_pkg::LINK_W-1:0]   available_total;
        logic [sbfl_pkg::CNT_W-1:0]    borrow_total;
        logic [sbfl_pkg::CNT_W-1:0]    return_total;
    } t_pool_result;

    // The scoreboard owns its own copy of the free lists and the two registers.
    // Every accepted request is run through that copy at once, and the outcome is
    // queued until the block delivers the matching result.
    class buffer_pool_scoreboard;
        t_pool_result                      pending[$];
        logic [sbfl_pkg::LINK_W-1:0]       link_mem [sbfl_pkg::MAX_BUFFERS];
        logic [sbfl_pkg::LINK_W-1:0]       head [sbfl_pkg::MAX_SHARDS];
        logic [sbfl_pkg::LINK_W-1:0]       free_cnt [sbfl_pkg::MAX_SHARDS];
        logic [sbfl_pkg::CNT_W-1:0]        borrows;
        logic [sbfl_pkg::CNT_W-1:0]        returns;
        logic [sbfl_pkg::CFG_DATA_W-1:0]   cfg_buffers;
        logic [sbfl_pkg::SHARD_CNT_W-1:0]  cfg_shards;
        int unsigned failures;
        int unsigned requests;
        int unsigned reg_writes;
        int unsigned grants, empties, accepted_returns, rejects;

        // Register values outside the legal range are clamped, as the block does.
        function int unsigned pool_size();
            if (cfg_buffers == 0) return 1;
            if (cfg_buffers > sbfl_pkg::MAX_BUFFERS) return sbfl_pkg::MAX_BUFFERS;
            return cfg_buffers;
        endfunction

        function int unsigned active_shards();
            if (cfg_shards == 0) return 1;
            if (cfg_shards > sbfl_pkg::MAX_SHARDS) return sbfl_pkg::MAX_SHARDS;
            return cfg_shards;
        endfunction

        // Buffers are pushed in ascending order, so each list ends up descending.
        function void rebuild();
            int unsigned n;
            int unsigned k;
            int unsigned s;
            n = pool_size();
            k = active_shards();
            for (int i = 0; i < sbfl_pkg::MAX_SHARDS; i++) begin
                head[i] = sbfl_pkg::EMPTY_MARK;
                free_cnt[i] = '0;
            end
            for (int i = 0; i < sbfl_pkg::MAX_BUFFERS; i++) link_mem[i] = sbfl_pkg::EMPTY_MARK;
            for (int i = 0; i < n; i++) begin
                s = i % k;
                link_mem[i] = head[s];
                head[s] = sbfl_pkg::LINK_W'(i);
                free_cnt[s] = free_cnt[s] + 1'b1;
            end
        endfunction

        function void reset_state();
            cfg_buffers = sbfl_pkg::CFG_DATA_W'(sbfl_pkg::MAX_BUFFERS);
            cfg_shards = sbfl_pkg::SHARD_CNT_W'(1);
            borrows = '0;
            returns = '0;
            rebuild();
        endfunction

        // The counters survive a rebuild; an unknown index leaves everything alone.
        function void write_register(logic [sbfl_pkg::CFG_IDX_W-1:0] idx,
                                     logic [sbfl_pkg::CFG_DATA_W-1:0] data);
            reg_writes++;
            case (idx)
                sbfl_pkg::CFG_BUFFERS: begin
                    cfg_buffers = data;
                    rebuild();
                end
                sbfl_pkg::CFG_SHARDS: begin
                    cfg_shards = data[sbfl_pkg::SHARD_CNT_W-1:0];
                    rebuild();
                end
                default: ;
            endcase
        endfunction

        function t_pool_result note_request(logic op, logic [sbfl_pkg::SHARD_W-1:0] pref,
                                            logic [sbfl_pkg::BUF_W-1:0] idx);
            t_pool_result r;
            int unsigned k;
            int unsigned s;
            logic [sbfl_pkg::LINK_W-1:0] h;
            logic [sbfl_pkg::LINK_W-1:0] sum;
            k = active_shards();
            r.granted_index = '0;
            r.granted_shard = '0;
            requests++;
            if (op == sbfl_pkg::OP_BORROW) begin
                // Probe from the preferred shard onward, wrapping, until a list has a head.
                r.status = sbfl_pkg::ST_EMPTY;
                for (int n = 0; n < k; n++) begin
                    s = (pref % k + n) % k;
                    h = head[s];
                    if (r.status == sbfl_pkg::ST_EMPTY && h < sbfl_pkg::MAX_BUFFERS) begin
                        head[s] = link_mem[h[sbfl_pkg::BUF_W-1:0]];
                        free_cnt[s] = free_cnt[s] - 1'b1;
                        borrows = borrows + 1'b1;
                        r.granted_index = h[sbfl_pkg::BUF_W-1:0];
                        r.granted_shard = sbfl_pkg::SHARD_W'(s);
                        r.status = sbfl_pkg::ST_GRANTED;
                    end
                end
                if (r.status == sbfl_pkg::ST_GRANTED) grants++;
                else empties++;
            end else if (idx >= pool_size()) begin
                r.status = sbfl_pkg::ST_RANGE;
                rejects++;
            end else begin
                // A buffer already on a list is pushed again without complaint.
                s = idx % k;
                link_mem[idx] = head[s];
                head[s] = sbfl_pkg::LINK_W'(idx);
                free_cnt[s] = free_cnt[s] + 1'b1;
                returns = returns + 1'b1;
                r.status = sbfl_pkg::ST_RETURNED;
                accepted_returns++;
            end
            sum = '0;
            for (int i = 0; i < k; i++) sum = sum + free_cnt[i];
            r.available_total = sum;
            r.borrow_total = borrows;
            r.return_total = returns;
            pending.insert(pending.size(), r);
            return r;
        endfunction

        function void check_result(t_pool_result got);
            t_pool_result want;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: status %0d index %0d shard %0d avail %0d",
                             got.status, got.granted_index, got.granted_shard,
                             got.available_total);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.granted_index !== want.granted_index ||
                got.granted_shard !== want.granted_shard ||
                got.available_total !== want.available_total ||
                got.borrow_total !== want.borrow_total ||
                got.return_total !== want.return_total) begin
                failures++;
                if (failures <= 10) begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected: status %0d index %0d shard %0d avail %0d %s %0d %0d",
                             want.status, want.granted_index, want.granted_shard,
                             want.available_total, "borrows/returns",
                             want.borrow_total, want.return_total);
                    $display("  actual:   status %0d index %0d shard %0d avail %0d %s %0d %0d",
                             got.status, got.granted_index, got.granted_shard,
                             got.available_total, "borrows/returns",
                             got.borrow_total, got.return_total);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    sbfl_req_if req_ch ();
    sbfl_rsp_if rsp_ch ();
    sbfl_cfg_if cfg_ch ();

    sharded_buffer_free_list_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    buffer_pool_scoreboard sb;

    // Buffers currently lent out, as far as the scoreboard knows. Returning one of
    // these is a well-formed return; anything else is noise.
    logic [sbfl_pkg::BUF_W-1:0] on_loan[$];

    // Idle percentages of the request sender and the result receiver.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // Set by the stimulus, counted down by the receiver while it holds ready low.
    int hold_off_left = 0;
    int quiet_cycles = 0;

    // Pool sizes and shard counts per random phase; several are out of range
    // on purpose and must be clamped. The last phase picks both at random.
    int unsigned buf_tab [PHASES] = '{256, 4, 1, 9, 2, 16, 33, 7, 511, 3, 64, 0};
    int unsigned shard_tab [PHASES] = '{8, 3, 1, 15, 8, 5, 4, 2, 0, 7, 6, 3};

    always #10 clk = ~clk;

    // Offers one request and waits for the block to take it. The request is
    // predicted at the acceptance edge; a granted buffer goes on the loan list.
    task automatic send_request(input logic op, input logic [sbfl_pkg::SHARD_W-1:0] pref,
                                input logic [sbfl_pkg::BUF_W-1:0] idx);
        t_pool_result predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op <= op;
        req_ch.first_shard <= pref;
        req_ch.buffer_index <= idx;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        predicted = sb.note_request(op, pref, idx);
        if (predicted.status == sbfl_pkg::ST_GRANTED)
            on_loan.insert(on_loan.size(), predicted.granted_index);
    endtask

    // Withdraws the request channel and waits until every result has come back,
    // so the block is idle before a register write or the end of the run.
    task automatic drain_requests();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(input logic [sbfl_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [sbfl_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        sb.write_register(idx, data);
        // A rebuild puts every buffer back on the free lists.
        if (idx == sbfl_pkg::CFG_BUFFERS || idx == sbfl_pkg::CFG_SHARDS) on_loan.delete();
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result receiver: ready changes only at the falling edge. A hold-off request
    // keeps ready low for a long stretch so the block backs up and stalls requests.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_off_left = hold_off_left - 1;
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Every result taken from the block is checked against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_result('{status: rsp_ch.status,
                              granted_index: rsp_ch.granted_index,
                              granted_shard: rsp_ch.granted_shard,
                              available_total: rsp_ch.available_total,
                              borrow_total: rsp_ch.borrow_total,
                              return_total: rsp_ch.return_total});
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int roll;
        int pick;
        logic [sbfl_pkg::BUF_W-1:0] idx;

        sb = new();
        sb.reset_state();
        req_ch.valid = 1'b0;
        req_ch.op = sbfl_pkg::OP_BORROW;
        req_ch.first_shard = '0;
        req_ch.buffer_index = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = sbfl_pkg::CFG_BUFFERS;
        cfg_ch.data = '0;

        // Synchronous reset, released at a falling clock edge.
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, reset setting (256 buffers, one shard): the head is 255,
        // whatever shard is asked for.
        send_request(sbfl_pkg::OP_BORROW, 3'd7, 8'hFF);
        send_request(sbfl_pkg::OP_BORROW, 3'd0, 8'h00);
        send_request(sbfl_pkg::OP_RETURN, 3'd0, 8'hFF);
        drain_requests();

        // Three buffers in two shards: shard search with wrap, pool exhaustion,
        // out-of-range returns and a double return that leaves a buffer listed twice.
        write_register(sbfl_pkg::CFG_BUFFERS, 9'd3);
        write_register(sbfl_pkg::CFG_SHARDS, 9'd2);
        send_request(sbfl_pkg::OP_BORROW, 3'd5, 8'h00);
        send_request(sbfl_pkg::OP_BORROW, 3'd1, 8'hAA);
        send_request(sbfl_pkg::OP_BORROW, 3'd0, 8'h55);
        send_request(sbfl_pkg::OP_BORROW, 3'd7, 8'hFF);
        send_request(sbfl_pkg::OP_RETURN, 3'd0, 8'd3);
        send_request(sbfl_pkg::OP_RETURN, 3'd7, 8'hFF);
        send_request(sbfl_pkg::OP_RETURN, 3'd2, 8'd1);
        send_request(sbfl_pkg::OP_RETURN, 3'd2, 8'd1);
        send_request(sbfl_pkg::OP_BORROW, 3'd0, 8'h00);
        send_request(sbfl_pkg::OP_BORROW, 3'd6, 8'h00);
        drain_requests();

        // Writes to unknown indexes change nothing, not even the free lists.
        write_register(2'd2, 9'h1AA);
        write_register(2'd3, 9'h055);
        send_request(sbfl_pkg::OP_BORROW, 3'd3, 8'h00);
        drain_requests();

        // Zero in both registers acts as one buffer in one shard.
        write_register(sbfl_pkg::CFG_SHARDS, 9'd0);
        write_register(sbfl_pkg::CFG_BUFFERS, 9'd0);
        send_request(sbfl_pkg::OP_BORROW, 3'd4, 8'h00);
        send_request(sbfl_pkg::OP_BORROW, 3'd2, 8'h00);
        send_request(sbfl_pkg::OP_RETURN, 3'd0, 8'd0);
        send_request(sbfl_pkg::OP_RETURN, 3'd0, 8'd1);
        drain_requests();

        // All ones in both registers: clamped to the full pool over eight shards.
        write_register(sbfl_pkg::CFG_SHARDS, 9'h1FF);
        write_register(sbfl_pkg::CFG_BUFFERS, 9'h1FF);
        send_request(sbfl_pkg::OP_BORROW, 3'd7, 8'h00);
        send_request(sbfl_pkg::OP_BORROW, 3'd3, 8'h00);
        send_request(sbfl_pkg::OP_RETURN, 3'd1, 8'hFF);
        send_request(sbfl_pkg::OP_BORROW, 3'd0, 8'h00);
        drain_requests();

        // Random part. Most requests borrow or return a buffer on loan; the rest
        // are out-of-range returns and returns of arbitrary (often free) buffers.
        for (int p = 0; p < PHASES; p++) begin
            case (p * 3 / PHASES)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 71;
                end
                1: begin
                    send_idle_pct = 71;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (p == PHASES - 1) begin
                buf_tab[p] = $urandom_range(0, 511);
                shard_tab[p] = $urandom_range(0, 511);
            end
            if (p % 4 == 2)
                write_register(2'd3, sbfl_pkg::CFG_DATA_W'($urandom_range(0, 511)));
            write_register(sbfl_pkg::CFG_SHARDS, sbfl_pkg::CFG_DATA_W'(shard_tab[p]));
            write_register(sbfl_pkg::CFG_BUFFERS, sbfl_pkg::CFG_DATA_W'(buf_tab[p]));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // With both sides running freely, the receiver stops for a long
                // stretch while requests keep coming, until the block backs up.
                if (p == 9 && n == 40) hold_off_left = HOLD_OFF_CYCLES;
                roll = $urandom_range(0, 99);
                if (roll < 47 || (roll < 88 && on_loan.size() == 0)) begin
                    send_request(sbfl_pkg::OP_BORROW,
                                 sbfl_pkg::SHARD_W'($urandom_range(0, 7)),
                                 sbfl_pkg::BUF_W'($urandom_range(0, 255)));
                end else if (roll < 88) begin
                    pick = $urandom_range(0, on_loan.size() - 1);
                    idx = on_loan[pick];
                    on_loan.delete(pick);
                    send_request(sbfl_pkg::OP_RETURN,
                                 sbfl_pkg::SHARD_W'($urandom_range(0, 7)), idx);
                end else if (roll < 96 && sb.pool_size() < sbfl_pkg::MAX_BUFFERS) begin
                    send_request(sbfl_pkg::OP_RETURN,
                                 sbfl_pkg::SHARD_W'($urandom_range(0, 7)),
                                 sbfl_pkg::BUF_W'($urandom_range(sb.pool_size(), 255)));
                end else begin
                    send_request(sbfl_pkg::OP_RETURN,
                                 sbfl_pkg::SHARD_W'($urandom_range(0, 7)),
                                 sbfl_pkg::BUF_W'($urandom_range(0, 255)));
                end
            end
            drain_requests();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d requests across %0d register writes and %0d settings.",
                 sb.requests, sb.reg_writes, PHASES + 5);
        $display("Outcomes: %0d granted, %0d pool empty, %0d returned, %0d rejected.",
                 sb.grants, sb.empties, sb.accepted_returns, sb.rejects);
        if (sb.pending.size() != 0)
            $display("%0d expected results never arrived", sb.pending.size());
        if (sb.failures > 10)
            $display("%0d mismatches in total", sb.failures);
        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
